// File: hw/rtl/radp_pkg.sv
// Shared types, constants and character decode for the radix integer parser.
package radp_pkg;

	localparam int ACC_WIDTH_DEF = 64;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_RADIX_MODE    = 2'd0;
	localparam logic [1:0] REG_WIDE_RESULT   = 2'd1;
	localparam logic [1:0] REG_UNSIGNED_MODE = 2'd2;

	// Radix mode codes.
	localparam logic [1:0] RADIX_BIN = 2'd0;
	localparam logic [1:0] RADIX_OCT = 2'd1;
	localparam logic [1:0] RADIX_DEC = 2'd2;
	localparam logic [1:0] RADIX_HEX = 2'd3;

	// Character codes.
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_X_LOWER = 8'h78;
	localparam logic [7:0] CH_X_UPPER = 8'h58;
	localparam logic [7:0] CH_B_LOWER = 8'h62;
	localparam logic [7:0] CH_B_UPPER = 8'h42;
	localparam logic [7:0] CH_MINUS   = 8'h2d;
	localparam logic [7:0] CH_PLUS    = 8'h2b;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0d;

	typedef struct packed {
		logic [1:0] radix_mode;
		logic       wide_result;
		logic       unsigned_mode;
	} cfg_t;

	typedef enum logic [4:0] {
		PH_DONE   = 5'b00001,
		PH_SPACE  = 5'b00010,
		PH_SIGNED = 5'b00100,
		PH_ZERO   = 5'b01000,
		PH_DIGITS = 5'b10000
	} phase_t;

	// Returns {is_digit, digit_value} for a character in the given radix.
	function automatic logic [4:0] digit_decode(input logic [7:0] c, input logic [1:0] mode);
		logic       hit;
		logic [3:0] v;
		logic       ok;
		begin
			hit = 1'b0;
			v   = 4'd0;
			if (c >= 8'h30 && c <= 8'h39) begin
				hit = 1'b1;
				v   = c[3:0];
			end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
				hit = 1'b1;
				v   = c[3:0] + 4'd9;
			end
			case (mode)
				RADIX_BIN: ok = (v < 4'd2);
				RADIX_OCT: ok = (v < 4'd8);
				RADIX_DEC: ok = (v < 4'd10);
				default:   ok = 1'b1;
			endcase
			digit_decode = {hit & ok, v};
		end
	endfunction

endpackage

// File: hw/rtl/radp_cfg.sv
// Configuration registers behind the APB-style port.
module radp_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output radp_pkg::cfg_t     cfg
);
	import radp_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radix_mode    <= RADIX_DEC;
			cfg_q.wide_result   <= 1'b1;
			cfg_q.unsigned_mode <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_RADIX_MODE:    cfg_q.radix_mode    <= pwdata[1:0];
				REG_WIDE_RESULT:   cfg_q.wide_result   <= pwdata[0];
				REG_UNSIGNED_MODE: cfg_q.unsigned_mode <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_RADIX_MODE:    prdata = {30'd0, cfg_q.radix_mode};
			REG_WIDE_RESULT:   prdata = {31'd0, cfg_q.wide_result};
			REG_UNSIGNED_MODE: prdata = {31'd0, cfg_q.unsigned_mode};
			default:           prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// File: hw/rtl/radp_parse.sv
// Parse state registers and the one-character step of the parser.
module radp_parse #(
	parameter int ACC_WIDTH = radp_pkg::ACC_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  radp_pkg::cfg_t cfg,
	input  logic           step_en,
	input  logic [7:0]     char_code,
	input  logic           start_flag,
	output logic           res_valid,
	output logic [63:0]    res_value
);
	import radp_pkg::*;

	localparam int NarrowW = (ACC_WIDTH < 32) ? ACC_WIDTH : 32;

	phase_t                 phase_q, eff_phase, phase_nxt;
	logic                   neg_q, eff_neg, neg_nxt;
	logic [ACC_WIDTH-1:0]   acc_q, eff_acc, acc_nxt;
	logic [ACC_WIDTH-1:0]   acc_mul, acc_step, signed_acc, digit_ext;
	logic [4:0]             dec;
	logic                   is_ws, prefix_mode, prefix_hit, sx;
	logic                   take_digit;
	logic [63:0]            wide_v, narrow_v, final_v;

	// A start mark restarts the parse before the character is looked at.
	assign eff_phase = start_flag ? PH_SPACE : phase_q;
	assign eff_neg   = start_flag ? 1'b0 : neg_q;
	assign eff_acc   = start_flag ? '0 : acc_q;

	assign dec         = digit_decode(char_code, cfg.radix_mode);
	assign is_ws       = (char_code == CH_SPACE) || (char_code >= CH_TAB && char_code <= CH_CR);
	assign prefix_mode = (cfg.radix_mode == RADIX_BIN) || (cfg.radix_mode == RADIX_HEX);
	assign prefix_hit  = ((cfg.radix_mode == RADIX_BIN) &&
	                      (char_code == CH_B_LOWER || char_code == CH_B_UPPER)) ||
	                     ((cfg.radix_mode == RADIX_HEX) &&
	                      (char_code == CH_X_LOWER || char_code == CH_X_UPPER));

	// Constant-radix multiply as shifts, with one add for decimal.
	always_comb begin
		case (cfg.radix_mode)
			RADIX_BIN: acc_mul = eff_acc << 1;
			RADIX_OCT: acc_mul = eff_acc << 3;
			RADIX_DEC: acc_mul = (eff_acc << 3) + (eff_acc << 1);
			default:   acc_mul = eff_acc << 4;
		endcase
	end
	assign digit_ext = {{(ACC_WIDTH-4){1'b0}}, dec[3:0]};
	assign acc_step  = acc_mul + digit_ext;

	// Final value: negate, wrap to the selected width, then extend.
	assign signed_acc = eff_neg ? ('0 - eff_acc) : eff_acc;
	assign sx         = ~cfg.unsigned_mode;

	generate
		if (ACC_WIDTH == 64) begin : g_wide_full
			assign wide_v = signed_acc;
		end else begin : g_wide_ext
			assign wide_v = {{(64-ACC_WIDTH){sx & signed_acc[ACC_WIDTH-1]}}, signed_acc};
		end
	endgenerate
	assign narrow_v = {{(64-NarrowW){sx & signed_acc[NarrowW-1]}}, signed_acc[NarrowW-1:0]};
	assign final_v  = cfg.wide_result ? wide_v : narrow_v;

	always_comb begin
		phase_nxt  = eff_phase;
		neg_nxt    = eff_neg;
		acc_nxt    = eff_acc;
		res_valid  = 1'b0;
		res_value  = final_v;
		take_digit = 1'b0;
		case (eff_phase)
			PH_SPACE: begin
				if (is_ws) begin
					phase_nxt = PH_SPACE;
				end else if (char_code == CH_MINUS) begin
					if (cfg.unsigned_mode) begin
						phase_nxt = PH_DONE;
						res_valid = 1'b1;
						res_value = 64'd0;
					end else begin
						neg_nxt   = 1'b1;
						phase_nxt = PH_SIGNED;
					end
				end else if (char_code == CH_PLUS) begin
					phase_nxt = PH_SIGNED;
				end else if (prefix_mode && char_code == CH_ZERO) begin
					phase_nxt = PH_ZERO;
				end else begin
					take_digit = 1'b1;
				end
			end
			PH_SIGNED: begin
				if (prefix_mode && char_code == CH_ZERO) begin
					phase_nxt = PH_ZERO;
				end else begin
					take_digit = 1'b1;
				end
			end
			PH_ZERO: begin
				if (prefix_hit) begin
					phase_nxt = PH_DIGITS;
				end else begin
					take_digit = 1'b1;
				end
			end
			PH_DIGITS: take_digit = 1'b1;
			default: phase_nxt = eff_phase;
		endcase
		if (take_digit) begin
			if (dec[4]) begin
				acc_nxt   = acc_step;
				phase_nxt = PH_DIGITS;
			end else begin
				phase_nxt = PH_DONE;
				res_valid = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DONE;
			neg_q   <= 1'b0;
			acc_q   <= '0;
		end else if (step_en) begin
			phase_q <= phase_nxt;
			neg_q   <= neg_nxt;
			acc_q   <= acc_nxt;
		end
	end

endmodule

// File: hw/rtl/radix_integer_parser_core.sv
// Top level of the radix integer parser: input stage, parse step, result register.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+--------------------------
//  char     | in        | char_valid / char_stall    | char_code[7:0], start_flag
//  value    | out       | value_valid / value_stall  | parsed_value[63:0]
//  config   | in        | psel/penable/pwrite/pready | paddr[3:0], pwdata, prdata
//
// One character is taken every cycle unless the input stage is stalled. A
// character is captured in the input stage; when it steps, the parse step
// updates the phase, sign and accumulator and, on the terminating character,
// loads the result register, which drives value_valid.
// The rate is set by the loop through the parse state: one shift-add per cycle while not stalled.
// Reset puts the parser in the finished phase and the registers at decimal,
// 64-bit, signed. A stalled result only holds the input stage when the waiting
// character would itself produce a result; other characters keep flowing.
module radix_integer_parser_core #(
	parameter int ACC_WIDTH = radp_pkg::ACC_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// character channel
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  char_code,
	input  logic        start_flag,
	// result channel
	output logic        value_valid,
	input  logic        value_stall,
	output logic [63:0] parsed_value,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import radp_pkg::*;

	cfg_t        cfg;
	logic        valid_s1;
	logic [7:0]  char_code_s1;
	logic        start_flag_s1;
	logic        char_accept;
	logic        step_en;
	logic        res_valid;
	logic [63:0] res_value;
	logic        out_load;
	logic        out_valid_q;
	logic [63:0] out_value_q;

	radp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The input stage moves on unless it holds a result-producing character
	// while the result register is full and stalled.
	assign step_en     = valid_s1 & (~res_valid | ~out_valid_q | ~value_stall);
	assign char_stall  = valid_s1 & ~step_en;
	assign char_accept = char_valid & ~char_stall;
	assign out_load    = step_en & res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_accept) begin
			valid_s1 <= 1'b1;
		end else if (step_en) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (char_accept) begin
			char_code_s1  <= char_code;
			start_flag_s1 <= start_flag;
		end
	end

	radp_parse #(
		.ACC_WIDTH (ACC_WIDTH)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.step_en    (step_en),
		.char_code  (char_code_s1),
		.start_flag (start_flag_s1),
		.res_valid  (res_valid),
		.res_value  (res_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!value_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q <= res_value;
		end
	end

	assign value_valid  = out_valid_q;
	assign parsed_value = out_value_q;

	// The input stage only stalls when it is holding a character.
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> valid_s1)
		else $error("character stall raised with an empty input stage");

	// A result is only loaded from a character that is stepping through the parser.
	a_load_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (valid_s1 && step_en))
		else $error("result register loaded without a parse step");

	// A taken result is not repeated unless a new one is loaded.
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !value_stall && !out_load) |=> !out_valid_q)
		else $error("result transaction repeated");

	// A stalled pending result must never be overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && value_stall) |-> !out_load)
		else $error("pending result overwritten");

endmodule
